FILE: rtl/gmsp_pkg.sv
// ----------------------------------------------------------------------------
// gmsp_pkg
// Shared types, codes and constants of the geared motor step positioner.
// ----------------------------------------------------------------------------
package gmsp_pkg;

  // Highest gear index; gear g sits at encoder position g * step_spacing.
  localparam int unsigned TOP_GEAR = 10;

  localparam int unsigned GEAR_W    = 4;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned DRIVE_W   = 10;
  localparam int unsigned SPACING_W = 12;
  localparam int unsigned RUN_W     = 16;
  localparam int unsigned TIME_W    = 20;
  localparam int unsigned DRIFT_W   = 7;
  localparam int unsigned BAND_W    = 10;
  localparam int unsigned SENSE_W   = 16;
  localparam int unsigned PROD_W    = 2 * SENSE_W;

  // Power is current * battery / POWER_SCALE.
  localparam int unsigned POWER_SCALE = 1000;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // Register reset values.
  localparam logic [SPACING_W-1:0] RST_STEP_SPACING  = 12'd200;
  localparam logic [DRIVE_W-1:0]   RST_DRIVE_LEVEL   = 10'd1000;
  localparam logic [RUN_W-1:0]     RST_POWER_LIMIT   = 16'd390;
  localparam logic [RUN_W-1:0]     RST_OC_SAMPLES    = 16'd5000;
  localparam logic [TIME_W-1:0]    RST_TIMEOUT       = 20'd700000;
  localparam logic [POS_W-1:0]     RST_CALIB_POS     = 16'd500;
  localparam logic [BAND_W-1:0]    RST_DEADBAND      = 10'd10;
  localparam logic [DRIFT_W-1:0]   RST_DRIFT_PERIOD  = 7'd70;

  typedef enum logic [2:0] {
    KIND_SAMPLE = 3'd0,
    KIND_PULSE  = 3'd1,
    KIND_CALIB  = 3'd2,
    KIND_LEFT   = 3'd3,
    KIND_RIGHT  = 3'd4,
    KIND_UP     = 3'd5,
    KIND_DOWN   = 3'd6,
    KIND_SETPOS = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_MOVING      = 3'd1,
    ST_ARRIVED     = 3'd2,
    ST_AT_END      = 3'd3,
    ST_OVERCURRENT = 3'd4,
    ST_TIMEOUT     = 3'd5,
    ST_LIMIT       = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    REG_STEP_SPACING = 3'd0,
    REG_DRIVE_LEVEL  = 3'd1,
    REG_POWER_LIMIT  = 3'd2,
    REG_OC_SAMPLES   = 3'd3,
    REG_TIMEOUT      = 3'd4,
    REG_CALIB_POS    = 3'd5,
    REG_DEADBAND     = 3'd6,
    REG_DRIFT_PERIOD = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [SPACING_W-1:0] step_spacing;
    logic [DRIVE_W-1:0]   drive_level;
    logic [RUN_W-1:0]     power_limit;
    logic [RUN_W-1:0]     oc_samples;
    logic [TIME_W-1:0]    timeout_samples;
    logic [POS_W-1:0]     calib_pos;
    logic [BAND_W-1:0]    deadband;
    logic [DRIFT_W-1:0]   drift_period;
  } cfg_t;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    kind_t              kind;
    logic [PROD_W-1:0]  product;
    logic               left_level;
    logic               right_level;
    logic [POS_W-1:0]   position_value;
  } entry_t;

endpackage

FILE: rtl/geared_motor_step_positioner_unit.sv
// ----------------------------------------------------------------------------
// geared_motor_step_positioner_unit
// Encoder-counting positioner that steps a motor between gear positions,
// with drift correction, limit handling, overcurrent and timeout stops.
// ----------------------------------------------------------------------------
//  channel   handshake               contents
//  -------   ---------------------   --------------------------------------
//  in        in_valid / in_stall     kind, sensor readings, limits, position
//  out       out_valid / out_stall   drive compares, position, gear, status
//  apb       psel/penable/pready     eight 32-bit registers at 4*index
//
//  One word per cycle sustained while the output is not stalled; a result
//  is registered in its queue slot, then in the back-end output register.
//  While the output stalls, the two-entry queue takes two more words before
//  in_stall rises.
//  Reset is synchronous; it clears the state, queue and output valid.
//  A stalled output word holds until it is taken.
// ----------------------------------------------------------------------------
module geared_motor_step_positioner_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gmsp_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [gmsp_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [gmsp_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          kind,
  input  logic [gmsp_pkg::SENSE_W-1:0]        motor_current,
  input  logic [gmsp_pkg::SENSE_W-1:0]        battery_level,
  input  logic                                left_limit_level,
  input  logic                                right_limit_level,
  input  logic signed [gmsp_pkg::POS_W-1:0]   position_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gmsp_pkg::DRIVE_W-1:0]        drive_forward,
  output logic [gmsp_pkg::DRIVE_W-1:0]        drive_reverse,
  output logic signed [gmsp_pkg::POS_W-1:0]   position,
  output logic [gmsp_pkg::GEAR_W-1:0]         gear_index,
  output logic [2:0]                          move_status
);

  gmsp_pkg::cfg_t   cfg;
  gmsp_pkg::entry_t push_entry;
  gmsp_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             q_valid;
  logic             q_full;

  gmsp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gmsp_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .kind              (kind),
    .motor_current     (motor_current),
    .battery_level     (battery_level),
    .left_limit_level  (left_limit_level),
    .right_limit_level (right_limit_level),
    .position_value    (position_value),
    .q_full            (q_full),
    .push              (push),
    .entry             (push_entry)
  );

  gmsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_full     (q_full),
    .head       (head)
  );

  gmsp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_entry       (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive_forward (drive_forward),
    .drive_reverse (drive_reverse),
    .position      (position),
    .gear_index    (gear_index),
    .move_status   (move_status)
  );

endmodule

FILE: rtl/gmsp_cfg.sv
// ----------------------------------------------------------------------------
// gmsp_cfg
// APB register file holding the positioner's configuration.
// ----------------------------------------------------------------------------
module gmsp_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gmsp_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [gmsp_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [gmsp_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output gmsp_pkg::cfg_t                      cfg
);

  gmsp_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = gmsp_pkg::reg_idx_t'(paddr[gmsp_pkg::APB_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_spacing    <= gmsp_pkg::RST_STEP_SPACING;
      cfg.drive_level     <= gmsp_pkg::RST_DRIVE_LEVEL;
      cfg.power_limit     <= gmsp_pkg::RST_POWER_LIMIT;
      cfg.oc_samples      <= gmsp_pkg::RST_OC_SAMPLES;
      cfg.timeout_samples <= gmsp_pkg::RST_TIMEOUT;
      cfg.calib_pos       <= gmsp_pkg::RST_CALIB_POS;
      cfg.deadband        <= gmsp_pkg::RST_DEADBAND;
      cfg.drift_period    <= gmsp_pkg::RST_DRIFT_PERIOD;
    end else if (wr_en) begin
      unique case (idx)
        gmsp_pkg::REG_STEP_SPACING: begin
          cfg.step_spacing <= pwdata[gmsp_pkg::SPACING_W-1:0];
        end
        gmsp_pkg::REG_DRIVE_LEVEL: begin
          cfg.drive_level <= pwdata[gmsp_pkg::DRIVE_W-1:0];
        end
        gmsp_pkg::REG_POWER_LIMIT: begin
          cfg.power_limit <= pwdata[gmsp_pkg::RUN_W-1:0];
        end
        gmsp_pkg::REG_OC_SAMPLES: begin
          cfg.oc_samples <= pwdata[gmsp_pkg::RUN_W-1:0];
        end
        gmsp_pkg::REG_TIMEOUT: begin
          cfg.timeout_samples <= pwdata[gmsp_pkg::TIME_W-1:0];
        end
        gmsp_pkg::REG_CALIB_POS: begin
          cfg.calib_pos <= pwdata[gmsp_pkg::POS_W-1:0];
        end
        gmsp_pkg::REG_DEADBAND: begin
          cfg.deadband <= pwdata[gmsp_pkg::BAND_W-1:0];
        end
        gmsp_pkg::REG_DRIFT_PERIOD: begin
          cfg.drift_period <= pwdata[gmsp_pkg::DRIFT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      gmsp_pkg::REG_STEP_SPACING: prdata = 32'(cfg.step_spacing);
      gmsp_pkg::REG_DRIVE_LEVEL:  prdata = 32'(cfg.drive_level);
      gmsp_pkg::REG_POWER_LIMIT:  prdata = 32'(cfg.power_limit);
      gmsp_pkg::REG_OC_SAMPLES:   prdata = 32'(cfg.oc_samples);
      gmsp_pkg::REG_TIMEOUT:      prdata = 32'(cfg.timeout_samples);
      gmsp_pkg::REG_CALIB_POS:    prdata = 32'($signed(cfg.calib_pos));
      gmsp_pkg::REG_DEADBAND:     prdata = 32'(cfg.deadband);
      gmsp_pkg::REG_DRIFT_PERIOD: prdata = 32'(cfg.drift_period);
      default:                    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/gmsp_front.sv
// ----------------------------------------------------------------------------
// gmsp_front
// Accepts input words, decodes the kind and forms the current-battery
// product that the back end compares against the power limit.
// ----------------------------------------------------------------------------
module gmsp_front (
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       kind,
  input  logic [gmsp_pkg::SENSE_W-1:0]     motor_current,
  input  logic [gmsp_pkg::SENSE_W-1:0]     battery_level,
  input  logic                             left_limit_level,
  input  logic                             right_limit_level,
  input  logic [gmsp_pkg::POS_W-1:0]       position_value,
  input  logic                             q_full,
  output logic                             push,
  output gmsp_pkg::entry_t                 entry
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    entry.kind           = gmsp_pkg::kind_t'(kind);
    entry.product        = {16'b0, motor_current} * {16'b0, battery_level};
    entry.left_level     = left_limit_level;
    entry.right_level    = right_limit_level;
    entry.position_value = position_value;
  end

endmodule

FILE: rtl/gmsp_queue.sv
// ----------------------------------------------------------------------------
// gmsp_queue
// Short FIFO of decoded words between the front and the back end.
// ----------------------------------------------------------------------------
module gmsp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  gmsp_pkg::entry_t     push_entry,
  input  logic                 pop,
  output logic                 q_valid,
  output logic                 q_full,
  output gmsp_pkg::entry_t     head
);

  gmsp_pkg::entry_t                 slots [gmsp_pkg::QUEUE_DEPTH];
  logic [gmsp_pkg::QPTR_W-1:0]      wr_ptr;
  logic [gmsp_pkg::QPTR_W-1:0]      rd_ptr;
  logic [gmsp_pkg::QCNT_W-1:0]      count;

  assign q_valid = (count != '0);
  assign q_full  = (count == gmsp_pkg::QCNT_W'(gmsp_pkg::QUEUE_DEPTH));
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == gmsp_pkg::QPTR_W'(gmsp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == gmsp_pkg::QPTR_W'(gmsp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue read while empty");

endmodule

FILE: rtl/gmsp_back.sv
// ----------------------------------------------------------------------------
// gmsp_back
// Executes decoded words on the positioner state and holds the result word
// in an output register.
// ----------------------------------------------------------------------------
module gmsp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  gmsp_pkg::cfg_t                    cfg,
  input  logic                              q_valid,
  input  gmsp_pkg::entry_t                  q_entry,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gmsp_pkg::DRIVE_W-1:0]      drive_forward,
  output logic [gmsp_pkg::DRIVE_W-1:0]      drive_reverse,
  output logic signed [gmsp_pkg::POS_W-1:0] position,
  output logic [gmsp_pkg::GEAR_W-1:0]       gear_index,
  output logic [2:0]                        move_status
);

  localparam logic [gmsp_pkg::GEAR_W-1:0] TOP = gmsp_pkg::GEAR_W'(gmsp_pkg::TOP_GEAR);
  localparam logic signed [gmsp_pkg::POS_W-1:0] POS_MAX = 16'sh7FFF;
  localparam logic signed [gmsp_pkg::POS_W-1:0] POS_MIN = 16'sh8000;

  // Architectural state.
  logic signed [gmsp_pkg::POS_W-1:0]   pos_count;
  logic [gmsp_pkg::DRIFT_W-1:0]        drift_count;
  logic                                reverse_dir;
  logic                                limit_hit;
  logic [gmsp_pkg::GEAR_W-1:0]         cur_gear;
  logic [gmsp_pkg::GEAR_W-1:0]         target_gear;
  logic                                moving;
  logic                                moving_up;
  logic [gmsp_pkg::RUN_W-1:0]          oc_run;
  logic [gmsp_pkg::TIME_W-1:0]         timeout_run;
  logic [gmsp_pkg::DRIVE_W-1:0]        fwd_drive;
  logic [gmsp_pkg::DRIVE_W-1:0]        rev_drive;

  logic signed [gmsp_pkg::POS_W-1:0]   pos_count_next;
  logic [gmsp_pkg::DRIFT_W-1:0]        drift_count_next;
  logic                                reverse_dir_next;
  logic                                limit_hit_next;
  logic [gmsp_pkg::GEAR_W-1:0]         cur_gear_next;
  logic [gmsp_pkg::GEAR_W-1:0]         target_gear_next;
  logic                                moving_next;
  logic                                moving_up_next;
  logic [gmsp_pkg::RUN_W-1:0]          oc_run_next;
  logic [gmsp_pkg::TIME_W-1:0]         timeout_run_next;
  logic [gmsp_pkg::DRIVE_W-1:0]        fwd_drive_next;
  logic [gmsp_pkg::DRIVE_W-1:0]        rev_drive_next;
  gmsp_pkg::status_t                   status;

  // Datapath terms.
  logic [gmsp_pkg::GEAR_W-1:0]         step_gear;
  logic [gmsp_pkg::GEAR_W-1:0]         gear_sel;
  logic [gmsp_pkg::POS_W-1:0]          tgt;
  logic signed [gmsp_pkg::POS_W:0]     tgt_s;
  logic signed [gmsp_pkg::POS_W:0]     pos_s;
  logic signed [gmsp_pkg::POS_W+1:0]   diff;
  logic signed [gmsp_pkg::POS_W+1:0]   distance;
  logic                                fwd;
  logic                                in_band;
  logic                                arrived;
  logic [26:0]                         power_thr;
  logic                                over;
  logic                                take;

  assign take = q_valid && (!out_valid || !out_stall);
  assign pop  = take;

  always_comb begin
    step_gear = (q_entry.kind == gmsp_pkg::KIND_UP) ? cur_gear + 1'b1 : cur_gear - 1'b1;
    gear_sel  = (q_entry.kind == gmsp_pkg::KIND_SAMPLE) ? target_gear : step_gear;
    tgt       = {12'b0, gear_sel} * {4'b0, cfg.step_spacing};
    tgt_s     = $signed({1'b0, tgt});
    pos_s     = {pos_count[gmsp_pkg::POS_W-1], pos_count};
    diff      = {tgt_s[gmsp_pkg::POS_W], tgt_s} - {pos_s[gmsp_pkg::POS_W], pos_s};
    fwd       = tgt_s > pos_s;
    distance  = fwd ? diff : -diff;
    in_band   = distance <= $signed({8'b0, cfg.deadband});
    arrived   = moving_up ? (pos_s >= tgt_s) : (pos_s <= tgt_s);
    // floor(p / scale) > limit exactly when p >= (limit + 1) * scale.
    power_thr = ({11'b0, cfg.power_limit} + 27'd1) * 27'(gmsp_pkg::POWER_SCALE);
    over      = q_entry.product >= {5'b0, power_thr};
  end

  always_comb begin
    pos_count_next   = pos_count;
    drift_count_next = drift_count;
    reverse_dir_next = reverse_dir;
    limit_hit_next   = limit_hit;
    cur_gear_next    = cur_gear;
    target_gear_next = target_gear;
    moving_next      = moving;
    moving_up_next   = moving_up;
    oc_run_next      = oc_run;
    timeout_run_next = timeout_run;
    fwd_drive_next   = fwd_drive;
    rev_drive_next   = rev_drive;
    status           = moving ? gmsp_pkg::ST_MOVING : gmsp_pkg::ST_IDLE;

    unique case (q_entry.kind) inside
      gmsp_pkg::KIND_SAMPLE: begin
        if (!moving) begin
          status = gmsp_pkg::ST_IDLE;
        end else if (arrived) begin
          fwd_drive_next = '0;
          rev_drive_next = '0;
          moving_next    = 1'b0;
          cur_gear_next  = target_gear;
          status         = gmsp_pkg::ST_ARRIVED;
        end else if (over && (oc_run > cfg.oc_samples)) begin
          fwd_drive_next = '0;
          rev_drive_next = '0;
          moving_next    = 1'b0;
          status         = gmsp_pkg::ST_OVERCURRENT;
        end else begin
          if (!over) begin
            oc_run_next = '0;
          end else if (oc_run != '1) begin
            oc_run_next = oc_run + 1'b1;
          end
          if (limit_hit) begin
            fwd_drive_next = '0;
            rev_drive_next = '0;
            moving_next    = 1'b0;
            status         = gmsp_pkg::ST_LIMIT;
          end else if (timeout_run < cfg.timeout_samples) begin
            timeout_run_next = timeout_run + 1'b1;
            status           = gmsp_pkg::ST_MOVING;
          end else begin
            timeout_run_next = '0;
            fwd_drive_next   = '0;
            rev_drive_next   = '0;
            moving_next      = 1'b0;
            status           = gmsp_pkg::ST_TIMEOUT;
          end
        end
      end
      gmsp_pkg::KIND_PULSE: begin
        if (!reverse_dir) begin
          // Every drift_period + 1 forward pulses one count is dropped.
          if (drift_count >= cfg.drift_period) begin
            drift_count_next = '0;
          end else begin
            drift_count_next = drift_count + 1'b1;
            if (pos_count != POS_MAX) begin
              pos_count_next = pos_count + 16'sd1;
            end
          end
        end else if (pos_count != POS_MIN) begin
          pos_count_next = pos_count - 16'sd1;
        end
      end
      gmsp_pkg::KIND_CALIB: begin
        pos_count_next = $signed(cfg.calib_pos);
      end
      gmsp_pkg::KIND_LEFT: begin
        fwd_drive_next = '0;
        rev_drive_next = '0;
        limit_hit_next = 1'b1;
      end
      gmsp_pkg::KIND_RIGHT: begin
        if (q_entry.right_level) begin
          fwd_drive_next = '0;
          rev_drive_next = '0;
          limit_hit_next = 1'b1;
        end
      end
      gmsp_pkg::KIND_UP, gmsp_pkg::KIND_DOWN: begin
        if (moving) begin
          status = gmsp_pkg::ST_MOVING;
        end else if ((q_entry.kind == gmsp_pkg::KIND_UP) ? (cur_gear >= TOP)
                                                         : (cur_gear == '0)) begin
          status = gmsp_pkg::ST_AT_END;
        end else begin
          limit_hit_next = 1'b0;
          if (in_band) begin
            cur_gear_next = step_gear;
            status        = gmsp_pkg::ST_ARRIVED;
          end else if (fwd ? q_entry.right_level : q_entry.left_level) begin
            status = gmsp_pkg::ST_LIMIT;
          end else begin
            target_gear_next = step_gear;
            moving_next      = 1'b1;
            moving_up_next   = fwd;
            oc_run_next      = '0;
            timeout_run_next = '0;
            status           = gmsp_pkg::ST_MOVING;
            // A zero drive level leaves the direction bit alone.
            if (cfg.drive_level != '0) begin
              reverse_dir_next = !fwd;
              fwd_drive_next   = fwd ? cfg.drive_level : '0;
              rev_drive_next   = fwd ? '0 : cfg.drive_level;
            end else begin
              fwd_drive_next = '0;
              rev_drive_next = '0;
            end
          end
        end
      end
      gmsp_pkg::KIND_SETPOS: begin
        pos_count_next = $signed(q_entry.position_value);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_count   <= '0;
      drift_count <= '0;
      reverse_dir <= 1'b0;
      limit_hit   <= 1'b0;
      cur_gear    <= '0;
      target_gear <= '0;
      moving      <= 1'b0;
      moving_up   <= 1'b0;
      oc_run      <= '0;
      timeout_run <= '0;
      fwd_drive   <= '0;
      rev_drive   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        pos_count   <= pos_count_next;
        drift_count <= drift_count_next;
        reverse_dir <= reverse_dir_next;
        limit_hit   <= limit_hit_next;
        cur_gear    <= cur_gear_next;
        target_gear <= target_gear_next;
        moving      <= moving_next;
        moving_up   <= moving_up_next;
        oc_run      <= oc_run_next;
        timeout_run <= timeout_run_next;
        fwd_drive   <= fwd_drive_next;
        rev_drive   <= rev_drive_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      drive_forward <= fwd_drive_next;
      drive_reverse <= rev_drive_next;
      position      <= pos_count_next;
      gear_index    <= cur_gear_next;
      move_status   <= status;
    end
  end

  a_one_leg: assert property (@(posedge clk) disable iff (rst)
    !((fwd_drive != '0) && (rev_drive != '0)))
    else $error("both bridge legs driven");

  a_stopped_no_drive: assert property (@(posedge clk) disable iff (rst)
    !moving |-> (fwd_drive == '0) && (rev_drive == '0))
    else $error("drive active while not moving");

  a_gear_range: assert property (@(posedge clk) disable iff (rst)
    (cur_gear <= TOP) && (target_gear <= TOP))
    else $error("gear index beyond top gear");

  a_take_shows: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("processed word not presented");

endmodule
